// ===== rtl/lobm_pkg.sv =====
// Shared types, widths and codes for the limit order book matcher.
`timescale 1ns / 1ps
package lobm_pkg;

  // Default sizing
  localparam int STOCK_COUNT_DEF     = 16;
  localparam int ORDERS_PER_SIDE_DEF = 32;

  // Stream widths (tdata in whole bytes)
  localparam int S_TDATA_W = 112;
  localparam int S_TUSER_W = 1;
  localparam int M_TDATA_W = 120;
  localparam int M_TUSER_W = 3;

  // Result status codes
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_REJECT = 2'd1;
  localparam logic [1:0] STATUS_FULL   = 2'd2;

  // Classified order as it travels from front to back
  typedef struct packed {
    logic [31:0] order_time;
    logic [7:0]  trader;
    logic [3:0]  stock;
    logic        is_bid;
    logic [30:0] limit_price;
    logic [30:0] shares;
    logic [31:0] arrival;
    logic        skip;
    logic [1:0]  status;
  } order_t;

  // One resting order in the book memory
  typedef struct packed {
    logic [30:0] price;
    logic [30:0] shares;
    logic [7:0]  trader;
    logic [31:0] order_time;
    logic [31:0] arrival;
  } entry_t;

  // One result item
  typedef struct packed {
    logic [1:0]  status;
    logic        trade_valid;
    logic [7:0]  buyer;
    logic [7:0]  seller;
    logic [3:0]  trade_stock;
    logic [30:0] deal_price;
    logic [30:0] trade_shares;
    logic [31:0] trades_so_far;
    logic        last;
  } result_t;

endpackage

// ===== rtl/lobm_front.sv =====
// Front end: accepts orders, checks time order and stock range, numbers arrivals.
`timescale 1ns / 1ps
module lobm_front
  import lobm_pkg::*;
#(
  parameter int STOCK_COUNT = STOCK_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // order_time, trader, stock, limit_price, shares, pad
  input  logic [S_TUSER_W-1:0] s_tuser,  // is_bid
  output logic                 q_valid,
  input  logic                 q_ready,
  output order_t               q_item
);

  logic [31:0] latest_time;
  logic [31:0] arrival_counter;
  logic        time_back;
  logic        out_of_range;

  // Unpack and classify
  always_comb begin
    q_item.order_time  = s_tdata[31:0];
    q_item.trader      = s_tdata[39:32];
    q_item.stock       = s_tdata[43:40];
    q_item.is_bid      = s_tuser[0];
    q_item.limit_price = s_tdata[74:44];
    q_item.shares      = s_tdata[105:75];
    q_item.arrival     = arrival_counter;
    time_back          = s_tdata[31:0] < latest_time;
    out_of_range       = {28'd0, s_tdata[43:40]} >= 32'(STOCK_COUNT);
    q_item.skip        = time_back || out_of_range;
    q_item.status      = time_back ? STATUS_REJECT : STATUS_OK;
  end

  assign s_tready = q_ready;
  assign q_valid  = s_tvalid;

  // Advance time and arrival number on every order that enters the book logic
  always_ff @(posedge clk) begin
    if (rst) begin
      latest_time     <= '0;
      arrival_counter <= '0;
    end else if (s_tvalid && q_ready && !q_item.skip) begin
      latest_time     <= q_item.order_time;
      arrival_counter <= arrival_counter + 32'd1;
    end
  end

endmodule

// ===== rtl/lobm_queue.sv =====
// Two-entry order queue between front end and matching engine.
`timescale 1ns / 1ps
module lobm_queue
  import lobm_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  order_t in_item,
  output logic   out_valid,
  input  logic   out_ready,
  output order_t out_item
);

  order_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign out_item  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  // Track pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/lobm_back.sv =====
// Matching engine: scans the opposite book, emits trades, rests the remainder.
`timescale 1ns / 1ps
module lobm_back
  import lobm_pkg::*;
#(
  parameter int STOCK_COUNT     = STOCK_COUNT_DEF,
  parameter int ORDERS_PER_SIDE = ORDERS_PER_SIDE_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  order_t               q_item,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,  // buyer, seller, trade_stock, deal_price,
                                         // trade_shares, trades_so_far, pad
  output logic [M_TUSER_W-1:0] m_tuser,  // status, trade_valid
  output logic                 m_tlast
);

  localparam int OPS   = ORDERS_PER_SIDE;
  localparam int SIDES = 2 * STOCK_COUNT;
  localparam int SW    = $clog2(SIDES);
  localparam int KW    = (OPS > 1) ? $clog2(OPS) : 1;
  localparam int AW    = SW + KW;
  localparam int DEPTH = SIDES * (1 << KW);
  localparam int NW    = $clog2(OPS + 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LD1   = 4'd1;
  localparam logic [3:0] ST_LD2   = 4'd2;
  localparam logic [3:0] ST_LD3   = 4'd3;
  localparam logic [3:0] ST_SCAN  = 4'd4;
  localparam logic [3:0] ST_TRADE = 4'd5;
  localparam logic [3:0] ST_REST  = 4'd6;
  localparam logic [3:0] ST_WB1   = 4'd7;
  localparam logic [3:0] ST_WB2   = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;

  // True if entry a ranks ahead of entry b
  function automatic logic ranks_before(entry_t a, entry_t b, logic want_max);
    logic r;
    if (a.price != b.price) begin
      r = want_max ? (a.price > b.price) : (a.price < b.price);
    end else if (a.order_time != b.order_time) begin
      r = a.order_time < b.order_time;
    end else begin
      r = a.arrival < b.arrival;
    end
    return r;
  endfunction

  // Book storage
  entry_t           emem [DEPTH];
  entry_t           emem_q;
  logic [OPS-1:0]   vmem [SIDES];
  logic [OPS-1:0]   vmem_q;
  logic [SIDES-1:0] row_ok;

  logic [3:0]     state;
  logic [30:0]    qty;
  logic [NW-1:0]  n;
  logic [OPS-1:0] opp_valid;
  logic [OPS-1:0] own_valid;
  logic [KW:0]    k;
  logic           rd_vld;
  logic [KW-1:0]  rd_k;
  logic           best_found;
  logic [KW-1:0]  best_k;
  entry_t         best;
  logic           pend_valid;
  result_t        pend;
  result_t        res;
  logic [31:0]    trade_count;
  logic [1:0]     rest_status;

  logic [SW-1:0]  own_side;
  logic [SW-1:0]  opp_side;
  logic [SW-1:0]  v_raddr;
  logic [AW-1:0]  e_raddr;
  logic           e_we;
  logic [AW-1:0]  e_waddr;
  entry_t         e_wdata;
  logic           v_we;
  logic [SW-1:0]  v_waddr;
  logic [OPS-1:0] v_wdata;
  logic           out_free;
  logic           out_load;
  result_t        out_data;
  logic           crosses;
  logic [30:0]    q;
  logic           do_trade;
  logic [KW-1:0]  free_k;
  logic           own_full;
  result_t        new_trade;

  assign own_side = SW'({q_item.stock, q_item.is_bid});
  assign opp_side = SW'({q_item.stock, ~q_item.is_bid});
  assign v_raddr  = (state == ST_LD1) ? opp_side : own_side;
  assign e_raddr  = {opp_side, k[KW-1:0]};
  assign out_free = !m_tvalid || m_tready;
  assign own_full = &own_valid;
  assign q_ready  = (state == ST_FIN) && out_free;

  // Cross test and fill size against the best resting order
  always_comb begin
    crosses  = q_item.is_bid ? (best.price <= q_item.limit_price)
                             : (best.price >= q_item.limit_price);
    q        = (qty < best.shares) ? qty : best.shares;
    do_trade = (state == ST_TRADE) && best_found && crosses && (!pend_valid || out_free);
    new_trade.status        = STATUS_OK;
    new_trade.trade_valid   = 1'b1;
    new_trade.buyer         = q_item.is_bid ? q_item.trader : best.trader;
    new_trade.seller        = q_item.is_bid ? best.trader : q_item.trader;
    new_trade.trade_stock   = q_item.stock;
    new_trade.deal_price    = best.price;
    new_trade.trade_shares  = q;
    new_trade.trades_so_far = trade_count + 32'd1;
    new_trade.last          = 1'b0;
  end

  // Lowest free slot on the own side
  always_comb begin
    free_k = '0;
    for (int i = OPS - 1; i >= 0; i--) begin
      if (!own_valid[i]) begin
        free_k = KW'(i);
      end
    end
  end

  // Memory write and output load selection
  always_comb begin
    e_we     = 1'b0;
    e_waddr  = {opp_side, best_k};
    e_wdata  = best;
    v_we     = 1'b0;
    v_waddr  = opp_side;
    v_wdata  = opp_valid;
    out_load = 1'b0;
    out_data = pend;
    case (state)
      ST_TRADE: begin
        if (do_trade) begin
          e_we           = 1'b1;
          e_wdata.shares = best.shares - q;
          out_load       = pend_valid;
        end
      end
      ST_REST: begin
        e_waddr            = {own_side, free_k};
        e_wdata.price      = q_item.limit_price;
        e_wdata.shares     = qty;
        e_wdata.trader     = q_item.trader;
        e_wdata.order_time = q_item.order_time;
        e_wdata.arrival    = q_item.arrival;
        e_we               = (qty != 31'd0) && !own_full;
      end
      ST_WB1: begin
        v_we = 1'b1;
      end
      ST_WB2: begin
        v_we    = 1'b1;
        v_waddr = own_side;
        v_wdata = own_valid;
      end
      ST_FIN: begin
        out_load = out_free;
        if (pend_valid) begin
          out_data.status = rest_status;
          out_data.last   = 1'b1;
        end else begin
          out_data               = '0;
          out_data.status        = rest_status;
          out_data.trades_so_far = trade_count;
          out_data.last          = 1'b1;
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // Book memories
  always_ff @(posedge clk) begin
    emem_q <= emem[e_raddr];
    if (e_we) begin
      emem[e_waddr] <= e_wdata;
    end
  end

  always_ff @(posedge clk) begin
    vmem_q <= vmem[v_raddr];
    if (v_we) begin
      vmem[v_waddr] <= v_wdata;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res <= out_data;
    end
  end

  assign m_tdata = {6'd0, res.trades_so_far, res.trade_shares, res.deal_price,
                    res.trade_stock, res.seller, res.buyer};
  assign m_tuser = {res.trade_valid, res.status};
  assign m_tlast = res.last;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      row_ok      <= '0;
      pend_valid  <= 1'b0;
      trade_count <= '0;
      rd_vld      <= 1'b0;
      best_found  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            qty         <= q_item.shares;
            n           <= '0;
            rest_status <= q_item.status;
            state       <= q_item.skip ? ST_FIN : ST_LD1;
          end
        end
        ST_LD1: begin
          state <= ST_LD2;
        end
        ST_LD2: begin
          opp_valid <= row_ok[opp_side] ? vmem_q : '0;
          state     <= ST_LD3;
        end
        ST_LD3: begin
          own_valid  <= row_ok[own_side] ? vmem_q : '0;
          k          <= '0;
          rd_vld     <= 1'b0;
          best_found <= 1'b0;
          state      <= (qty == 31'd0) ? ST_REST : ST_SCAN;
        end
        ST_SCAN: begin
          // Issue one read a cycle, fold the previous one into the best
          if (k != (KW + 1)'(OPS)) begin
            rd_vld <= 1'b1;
            rd_k   <= k[KW-1:0];
            k      <= k + 1'b1;
          end else begin
            rd_vld <= 1'b0;
          end
          if (rd_vld && opp_valid[rd_k] &&
              (!best_found || ranks_before(emem_q, best, !q_item.is_bid))) begin
            best       <= emem_q;
            best_k     <= rd_k;
            best_found <= 1'b1;
          end
          if (k == (KW + 1)'(OPS) && !rd_vld) begin
            state <= ST_TRADE;
          end
        end
        ST_TRADE: begin
          if (!best_found || !crosses) begin
            state <= ST_REST;
          end else if (do_trade) begin
            pend        <= new_trade;
            pend_valid  <= 1'b1;
            trade_count <= trade_count + 32'd1;
            qty         <= qty - q;
            n           <= n + 1'b1;
            if (best.shares == q) begin
              opp_valid[best_k] <= 1'b0;
            end
            k          <= '0;
            rd_vld     <= 1'b0;
            best_found <= 1'b0;
            state      <= (qty == q || n + 1'b1 == NW'(OPS)) ? ST_REST : ST_SCAN;
          end
        end
        ST_REST: begin
          if (qty != 31'd0) begin
            if (own_full) begin
              rest_status <= STATUS_FULL;
            end else begin
              own_valid[free_k] <= 1'b1;
            end
          end
          state <= ST_WB1;
        end
        ST_WB1: begin
          row_ok[opp_side] <= 1'b1;
          state            <= ST_WB2;
        end
        ST_WB2: begin
          row_ok[own_side] <= 1'b1;
          state            <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // No trade held over between orders
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("trade held while idle");

  // Trade count moves only when a trade is taken
  a_count_only_trade: assert property (@(posedge clk) disable iff (rst)
    !do_trade |=> (trade_count == $past(trade_count)))
    else $error("trade count moved without a trade");

  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_load && m_tvalid) |-> m_tready)
    else $error("output overwritten");

  // Trades per order stay within one side's depth
  a_trade_bound: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (n <= NW'(OPS)))
    else $error("too many trades for one order");

endmodule

// ===== rtl/limit_order_book_matcher.sv =====
// Top level of the limit order book matcher.
//
//  channel | direction | tdata                               | tuser                | tlast
//  s_*     | in        | order_time,trader,stock,price,shares | is_bid               | -
//  m_*     | out       | buyer,seller,stock,price,shares,cnt  | status,trade_valid   | last result
//
//  A rejected or out-of-range order goes from idle straight to the engine's final state.
//  An accepted order scans the opposite side T + 1 times for T trades, or T times when the
//  last trade fills it or reaches the side's depth, each through the single read port
//  of the book memory. A stalled output holds the engine. Reset is synchronous; book rows
//  read as empty until first written. The queue lets orders enter while the engine or the
//  output stalls.
`timescale 1ns / 1ps
module limit_order_book_matcher
  import lobm_pkg::*;
#(
  parameter int STOCK_COUNT     = STOCK_COUNT_DEF,
  parameter int ORDERS_PER_SIDE = ORDERS_PER_SIDE_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // order_time, trader, stock, limit_price, shares, pad
  input  logic [S_TUSER_W-1:0] s_tuser,  // is_bid
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,  // buyer, seller, trade_stock, deal_price,
                                         // trade_shares, trades_so_far, pad
  output logic [M_TUSER_W-1:0] m_tuser,  // status, trade_valid
  output logic                 m_tlast
);

  logic   f_valid;
  logic   f_ready;
  order_t f_item;
  logic   b_valid;
  logic   b_ready;
  order_t b_item;

  lobm_front #(
    .STOCK_COUNT (STOCK_COUNT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_item   (f_item)
  );

  lobm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_item  (b_item)
  );

  lobm_back #(
    .STOCK_COUNT     (STOCK_COUNT),
    .ORDERS_PER_SIDE (ORDERS_PER_SIDE)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (b_valid),
    .q_ready  (b_ready),
    .q_item   (b_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
